### sv/kpc_pkg.sv
// Shared types, codes and reset constants of the key press classifier.
package kpc_pkg;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned HoldW    = 9;
  localparam int unsigned TmoW     = 10;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_LOCK_MODE     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SHORT_TICKS   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LONG_TICKS    = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_TIMEOUT_TICKS = 2'd3;

  // Configuration reset values.
  localparam logic [7:0]      RST_SHORT_TICKS   = 8'd5;
  localparam logic [7:0]      RST_LONG_TICKS    = 8'd230;
  localparam logic [TmoW-1:0] RST_TIMEOUT_TICKS = 10'd900;

  // Tracked key state codes.
  localparam logic [2:0] TRK_IDLE   = 3'd0;
  localparam logic [2:0] TRK_DOWN   = 3'd1;
  localparam logic [2:0] TRK_UP     = 3'd2;
  localparam logic [2:0] TRK_SET    = 3'd3;
  localparam logic [2:0] TRK_PLAY   = 3'd4;
  localparam logic [2:0] TRK_RECORD = 3'd5;

  // Reported key codes.
  localparam logic [2:0] CODE_DOWN        = 3'd0;
  localparam logic [2:0] CODE_UP          = 3'd1;
  localparam logic [2:0] CODE_UP_LONG     = 3'd2;
  localparam logic [2:0] CODE_SET         = 3'd3;
  localparam logic [2:0] CODE_SET_LONG    = 3'd4;
  localparam logic [2:0] CODE_ESCAPE      = 3'd5;
  localparam logic [2:0] CODE_RECORD      = 3'd6;
  localparam logic [2:0] CODE_RECORD_LONG = 3'd7;

  typedef struct packed {
    logic            lock_mode;
    logic [7:0]      short_ticks;
    logic [7:0]      long_ticks;
    logic [TmoW-1:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic down_level;
    logic up_level;
    logic set_level;
    logic play_level;
    logic record_level;
    logic set_event;
  } sample_t;

endpackage

### sv/kpc_cfg_regs.sv
// Configuration registers of the key press classifier.
module kpc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           we_i,
  input  logic [kpc_pkg::CfgIdxW-1:0]    addr_i,
  input  logic [kpc_pkg::CfgDataW-1:0]   wdata_i,
  output kpc_pkg::cfg_t                  cfg_o
);
  import kpc_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lock_mode     <= 1'b0;
      cfg_q.short_ticks   <= RST_SHORT_TICKS;
      cfg_q.long_ticks    <= RST_LONG_TICKS;
      cfg_q.timeout_ticks <= RST_TIMEOUT_TICKS;
    end else if (we_i) begin
      case (addr_i)
        CFG_LOCK_MODE:     cfg_q.lock_mode     <= wdata_i[0];
        CFG_SHORT_TICKS:   cfg_q.short_ticks   <= wdata_i[7:0];
        CFG_LONG_TICKS:    cfg_q.long_ticks    <= wdata_i[7:0];
        CFG_TIMEOUT_TICKS: cfg_q.timeout_ticks <= wdata_i[TmoW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/kpc_core.sv
// Key tracking state and per-sample classification logic.
module kpc_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  kpc_pkg::sample_t sample_i,
  input  kpc_pkg::cfg_t    cfg_i,
  output logic             res_valid_o,
  output logic [2:0]       res_code_o
);
  import kpc_pkg::*;

  logic [2:0]       key_q, key_d;
  logic [HoldW-1:0] hold_q, hold_d;
  logic [TmoW-1:0]  tmo_q, tmo_d;
  logic             pend_q, pend_d;

  logic             timed;
  logic             clr;
  logic [HoldW-1:0] hold_inc;
  logic [HoldW-1:0] short_x;
  logic [HoldW-1:0] long_x;

  assign timed    = (key_q == TRK_DOWN) || (key_q == TRK_UP) || (key_q == TRK_SET);
  assign hold_inc = hold_q + HoldW'(1);
  assign short_x  = {1'b0, cfg_i.short_ticks};
  assign long_x   = {1'b0, cfg_i.long_ticks};

  always_comb begin
    key_d       = key_q;
    hold_d      = hold_q;
    tmo_d       = tmo_q;
    pend_d      = pend_q | sample_i.set_event;
    res_valid_o = 1'b0;
    res_code_o  = CODE_DOWN;
    clr         = 1'b0;
    if (timed && (tmo_q >= cfg_i.timeout_ticks)) begin
      clr = 1'b1;
    end else begin
      if (timed) begin
        tmo_d = tmo_q + TmoW'(1);
      end
      case (key_q)
        TRK_DOWN: begin
          if (hold_inc > short_x) begin
            res_valid_o = 1'b1;
            res_code_o  = CODE_DOWN;
            clr         = 1'b1;
          end else begin
            hold_d = hold_inc;
          end
        end
        TRK_UP: begin
          if (!cfg_i.lock_mode && (hold_q > short_x)) begin
            // Unlocked: a press still held past the short count reports up.
            res_valid_o = !sample_i.up_level;
            res_code_o  = CODE_UP;
            clr         = 1'b1;
          end else if (cfg_i.lock_mode && (hold_q > long_x)) begin
            res_valid_o = 1'b1;
            res_code_o  = CODE_UP_LONG;
            clr         = 1'b1;
          end else if (cfg_i.lock_mode && sample_i.up_level) begin
            res_valid_o = 1'b1;
            res_code_o  = CODE_UP;
            clr         = 1'b1;
          end else begin
            hold_d = hold_inc;
          end
        end
        TRK_SET, TRK_RECORD: begin
          if (((key_q == TRK_SET) ? sample_i.set_level : sample_i.record_level) &&
              (hold_q <= long_x)) begin
            res_valid_o = 1'b1;
            res_code_o  = (key_q == TRK_SET) ? CODE_SET : CODE_RECORD;
            clr         = 1'b1;
          end else if (hold_inc > long_x) begin
            res_valid_o = 1'b1;
            res_code_o  = (key_q == TRK_SET) ? CODE_SET_LONG : CODE_RECORD_LONG;
            clr         = 1'b1;
          end else begin
            hold_d = hold_inc;
          end
        end
        TRK_PLAY: begin
          // Escape only when play is let go on the very next sample.
          res_valid_o = sample_i.play_level;
          res_code_o  = CODE_ESCAPE;
          clr         = 1'b1;
        end
        default: begin
          key_d  = TRK_IDLE;
          hold_d = '0;
          tmo_d  = '0;
          if (!sample_i.down_level) begin
            key_d = TRK_DOWN;
          end else if (!sample_i.up_level) begin
            key_d = TRK_UP;
          end else if (pend_d && !sample_i.set_level) begin
            key_d  = TRK_SET;
            pend_d = 1'b0;
          end else if (!sample_i.play_level) begin
            key_d = TRK_PLAY;
          end else if (!sample_i.record_level) begin
            key_d = TRK_RECORD;
          end
        end
      endcase
    end
    if (clr) begin
      key_d  = TRK_IDLE;
      hold_d = '0;
      tmo_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= TRK_IDLE;
      hold_q <= '0;
      tmo_q  <= '0;
      pend_q <= 1'b0;
    end else if (step_i) begin
      key_q  <= key_d;
      hold_q <= hold_d;
      tmo_q  <= tmo_d;
      pend_q <= pend_d;
    end
  end

endmodule

### sv/key_press_classifier.sv
// Top level of the key press classifier: input register, core and result register.
//
// Each input transfer is one tick sample of five active-low key levels plus a
// set interrupt flag. A sample produces zero or one key code on the output
// channel, in sample order.
// An accepted sample waits in the input register; the classifier updates its
// key state from it and, when a code results, loads the result register, from
// which the key code is shown. Throughput is one sample per cycle while the
// result register is empty or its code is being taken.
// When the receiver stalls, the code waits in the result register; one more
// sample may wait in the input register, after which in_ready_o drops until
// the result is taken.
// Reset clears the key state, the pending set interrupt, both stages, and
// loads the configuration defaults (lock off, short 5, long 230, timeout 900).
// Configuration is written through cfg_we_i/cfg_addr_i/cfg_wdata_i; the user
// must write it only while idle, which the block itself does not enforce.
module key_press_classifier (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         down_level_i,
  input  logic                         up_level_i,
  input  logic                         set_level_i,
  input  logic                         play_level_i,
  input  logic                         record_level_i,
  input  logic                         set_event_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2:0]                   key_code_o,
  input  logic                         cfg_we_i,
  input  logic [kpc_pkg::CfgIdxW-1:0]  cfg_addr_i,
  input  logic [kpc_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import kpc_pkg::*;

  cfg_t       cfg;
  sample_t    smp_q;
  logic       smp_valid_q;
  logic       advance;
  logic       res_valid;
  logic [2:0] res_code;
  logic       out_valid_q;
  logic [2:0] code_q;
  logic       out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = smp_valid_q && out_free;
  assign in_ready_o = !smp_valid_q || advance;

  kpc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .addr_i  (cfg_addr_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  kpc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .sample_i    (smp_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_code_o  (res_code)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      smp_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      smp_q <= '{down_level:   down_level_i,
                 up_level:     up_level_i,
                 set_level:    set_level_i,
                 play_level:   play_level_i,
                 record_level: record_level_i,
                 set_event:    set_event_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      code_q <= res_code;
    end
  end

  assign out_valid_o = out_valid_q;
  assign key_code_o  = code_q;

endmodule

### sv/kpc_checker.sv
// Port-level checks of the key press classifier and their bind.
module kpc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [2:0] key_code_o
);

  // A stalled result holds its code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(key_code_o))
    else $error("stalled key code changed or dropped");

  // With the result register empty, the input side must never block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked while no result is pending");

  // A result transfer always frees room for a new sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |-> in_ready_o)
    else $error("input blocked while the result drains");

  // A fresh result follows its input transfer through the input and result registers.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result appeared without a preceding input transfer");

endmodule

bind key_press_classifier kpc_checker u_kpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .key_code_o  (key_code_o)
);

### tb/kpc_code_checker.sv
// Checker for the key press classifier: predicts key codes from accepted samples and compares.
`timescale 1ns / 100ps

module kpc_code_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  kpc_pkg::sample_t             sample_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [2:0]                   key_code_i,
  input  logic                         cfg_we_i,
  input  logic [kpc_pkg::CfgIdxW-1:0]  cfg_addr_i,
  input  logic [kpc_pkg::CfgDataW-1:0] cfg_wdata_i,
  output int                           mismatches_o,
  output int                           codes_pending_o,
  output int                           codes_checked_o,
  output int                           samples_taken_o
);
  import kpc_pkg::*;

  cfg_t            regs;
  logic [2:0]      tracked_key;
  logic [HoldW-1:0] ticks_held;
  logic [TmoW-1:0] ticks_toward_limit;
  logic            set_latched;

  logic [2:0] expected_codes [$];
  int         mismatch_count;
  int         checked_count;
  int         sample_count;

  function automatic void flag_mismatch(input string what, input logic [2:0] want,
                                        input logic [2:0] got);
    if (mismatch_count < 10) begin
      $display("%0t: %s: expected key code %0d, got %0d", $time, what, want, got);
    end
    mismatch_count++;
  endfunction

  // Advances the key tracker by one tick and tells whether a key code comes out.
  function automatic void classify_tick(input sample_t s, output bit emits,
                                        output logic [2:0] code);
    bit ends;
    emits = 1'b0;
    code  = CODE_DOWN;
    ends  = 1'b0;
    set_latched = set_latched | s.set_event;

    // Down, up and set presses are dropped once the hold limit is reached.
    if (tracked_key inside {TRK_DOWN, TRK_UP, TRK_SET}) begin
      if (ticks_toward_limit >= regs.timeout_ticks) ends = 1'b1;
      else ticks_toward_limit = ticks_toward_limit + TmoW'(1);
    end

    if (!ends) begin
      case (tracked_key)
        TRK_DOWN: begin
          ticks_held = ticks_held + HoldW'(1);
          if (ticks_held > regs.short_ticks) begin
            ends = 1'b1; emits = 1'b1; code = CODE_DOWN;
          end
        end
        TRK_UP: begin
          if (!regs.lock_mode) begin
            if (ticks_held > regs.short_ticks) begin
              ends = 1'b1;
              if (!s.up_level) begin
                emits = 1'b1; code = CODE_UP;
              end
            end
          end else if (ticks_held > regs.long_ticks) begin
            ends = 1'b1; emits = 1'b1; code = CODE_UP_LONG;
          end else if (s.up_level) begin
            ends = 1'b1; emits = 1'b1; code = CODE_UP;
          end
          if (!ends) ticks_held = ticks_held + HoldW'(1);
        end
        TRK_SET: begin
          if (s.set_level && ticks_held <= regs.long_ticks) begin
            ends = 1'b1; emits = 1'b1; code = CODE_SET;
          end else begin
            ticks_held = ticks_held + HoldW'(1);
            if (ticks_held > regs.long_ticks) begin
              ends = 1'b1; emits = 1'b1; code = CODE_SET_LONG;
            end
          end
        end
        TRK_PLAY: begin
          ends = 1'b1;
          if (s.play_level) begin
            emits = 1'b1; code = CODE_ESCAPE;
          end
        end
        TRK_RECORD: begin
          if (s.record_level && ticks_held <= regs.long_ticks) begin
            ends = 1'b1; emits = 1'b1; code = CODE_RECORD;
          end else begin
            ticks_held = ticks_held + HoldW'(1);
            if (ticks_held > regs.long_ticks) begin
              ends = 1'b1; emits = 1'b1; code = CODE_RECORD_LONG;
            end
          end
        end
        default: begin
          // Idle: the first pressed key in priority order starts a press (set only if latched).
          tracked_key        = TRK_IDLE;
          ticks_held         = '0;
          ticks_toward_limit = '0;
          if (!s.down_level) tracked_key = TRK_DOWN;
          else if (!s.up_level) tracked_key = TRK_UP;
          else if (set_latched && !s.set_level) begin
            set_latched = 1'b0;
            tracked_key = TRK_SET;
          end else if (!s.play_level) tracked_key = TRK_PLAY;
          else if (!s.record_level) tracked_key = TRK_RECORD;
        end
      endcase
    end

    if (ends) begin
      tracked_key        = TRK_IDLE;
      ticks_held         = '0;
      ticks_toward_limit = '0;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    bit         emits;
    logic [2:0] code;
    logic [2:0] want;
    if (!rst_ni) begin
      regs.lock_mode     = 1'b0;
      regs.short_ticks   = RST_SHORT_TICKS;
      regs.long_ticks    = RST_LONG_TICKS;
      regs.timeout_ticks = RST_TIMEOUT_TICKS;
      tracked_key        = TRK_IDLE;
      ticks_held         = '0;
      ticks_toward_limit = '0;
      set_latched        = 1'b0;
      expected_codes.delete();
      mismatch_count     = 0;
      checked_count      = 0;
      sample_count       = 0;
      mismatches_o      <= 0;
      codes_pending_o   <= 0;
      codes_checked_o   <= 0;
      samples_taken_o   <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_LOCK_MODE:     regs.lock_mode     = cfg_wdata_i[0];
          CFG_SHORT_TICKS:   regs.short_ticks   = cfg_wdata_i[7:0];
          CFG_LONG_TICKS:    regs.long_ticks    = cfg_wdata_i[7:0];
          CFG_TIMEOUT_TICKS: regs.timeout_ticks = cfg_wdata_i[TmoW-1:0];
          default: ;
        endcase
      end

      // The result side is handled first so that a stray code is never matched
      // against a prediction made at the same edge.
      if (out_valid_i && out_ready_i) begin
        if (expected_codes.size() == 0) begin
          flag_mismatch("unexpected key code", 3'bx, key_code_i);
        end else begin
          want = expected_codes.pop_front();
          if (want !== key_code_i) flag_mismatch("wrong key code", want, key_code_i);
          checked_count++;
        end
      end

      if (in_valid_i && in_ready_i) begin
        classify_tick(sample_i, emits, code);
        if (emits) expected_codes.push_back(code);
        sample_count++;
      end

      mismatches_o    <= mismatch_count;
      codes_pending_o <= expected_codes.size();
      codes_checked_o <= checked_count;
      samples_taken_o <= sample_count;
    end
  end

endmodule

### tb/tb_key_press_classifier.sv
// Testbench top of the key press classifier: clock, reset, key sample stimulus and verdict.
`timescale 1ns / 100ps

module tb_key_press_classifier;
  import kpc_pkg::*;

  localparam int unsigned NumPhases       = 9;
  localparam int unsigned PhaseItems      = 205;
  localparam int unsigned MaxHold         = 300;
  localparam int unsigned SettleCycles    = 6;
  localparam int unsigned LongStallCycles = 60;
  localparam int unsigned QuietLimit      = 2000;
  localparam logic [2:0]  TrackedKeys [5] = '{TRK_DOWN, TRK_UP, TRK_SET, TRK_PLAY, TRK_RECORD};

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  sample_t             in_sample = '1;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [2:0]          key_code;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_addr = CFG_LOCK_MODE;
  logic [CfgDataW-1:0] cfg_wdata = '0;

  int          mismatches;
  int          codes_pending;
  int          codes_checked;
  int          samples_taken;
  int unsigned send_idle_pct = 36;
  int unsigned recv_idle_pct = 70;
  int unsigned stall_requests = 0;
  int unsigned items_sent = 0;
  cfg_t        active_cfg;

  key_press_classifier u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .down_level_i   (in_sample.down_level),
    .up_level_i     (in_sample.up_level),
    .set_level_i    (in_sample.set_level),
    .play_level_i   (in_sample.play_level),
    .record_level_i (in_sample.record_level),
    .set_event_i    (in_sample.set_event),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .key_code_o     (key_code),
    .cfg_we_i       (cfg_we),
    .cfg_addr_i     (cfg_addr),
    .cfg_wdata_i    (cfg_wdata)
  );

  kpc_code_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .sample_i        (in_sample),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .key_code_i      (key_code),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .mismatches_o    (mismatches),
    .codes_pending_o (codes_pending),
    .codes_checked_o (codes_checked),
    .samples_taken_o (samples_taken)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The receiver normally stalls at random; a requested hold-off keeps it stalled
  // long enough for both stages of the block to fill.
  initial begin : receiver
    int unsigned served;
    served = 0;
    forever begin
      @(posedge clk);
      if (served != stall_requests) begin
        served++;
        out_ready <= 1'b0;
        repeat (LongStallCycles) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, QuietLimit);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic cfg_t make_cfg(input logic lock, input logic [7:0] short_t,
                                    input logic [7:0] long_t, input logic [TmoW-1:0] limit);
    cfg_t c;
    c.lock_mode     = lock;
    c.short_ticks   = short_t;
    c.long_ticks    = long_t;
    c.timeout_ticks = limit;
    return c;
  endfunction

  function automatic cfg_t phase_cfg(input int unsigned phase);
    cfg_t c;
    case (phase)
      0: c = make_cfg(1'b0, RST_SHORT_TICKS, RST_LONG_TICKS, RST_TIMEOUT_TICKS);
      1: c = make_cfg(1'b1, 8'd0, 8'd0, 10'd1);
      2: c = make_cfg(1'b0, 8'd255, 8'd255, 10'd1023);
      3: c = make_cfg(1'b1, 8'd3, 8'd6, 10'd0);
      5: c = make_cfg(1'b1, 8'd2, 8'd9, 10'd12);
      6: c = make_cfg(1'($urandom_range(1)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), 10'($urandom_range(1023)));
      7: c = make_cfg(1'b1, 8'd255, 8'd255, 10'd1023);
      default: c = make_cfg(1'($urandom_range(1)), 8'($urandom_range(12)),
                            8'($urandom_range(24)), 10'($urandom_range(1, 40)));
    endcase
    return c;
  endfunction

  // Hold lengths cluster around the thresholds of the current setting.
  function automatic int unsigned pick_hold();
    int unsigned hold;
    case ($urandom_range(4))
      0:       hold = $urandom_range(3);
      1:       hold = active_cfg.short_ticks + $urandom_range(3);
      2:       hold = active_cfg.long_ticks + $urandom_range(3);
      3:       hold = active_cfg.timeout_ticks + $urandom_range(3);
      default: hold = $urandom_range(active_cfg.long_ticks + 4);
    endcase
    if (hold > 0) hold--;
    return (hold > MaxHold) ? $urandom_range(MaxHold) : hold;
  endfunction

  function automatic sample_t key_sample(input logic [2:0] key, input logic evt);
    sample_t s;
    s = '1;
    s.set_event = evt;
    case (key)
      TRK_DOWN:   s.down_level = 1'b0;
      TRK_UP:     s.up_level = 1'b0;
      TRK_SET:    s.set_level = 1'b0;
      TRK_PLAY:   s.play_level = 1'b0;
      TRK_RECORD: s.record_level = 1'b0;
      default: ;
    endcase
    return s;
  endfunction

  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // One press: the picking tick, the hold ticks with some noise on the other
  // keys, then one or two released ticks.
  task automatic press_key(input logic [2:0] key, input int unsigned holds);
    sample_t    s;
    logic [5:0] noise;
    s = key_sample(key, (key == TRK_SET) ? ($urandom_range(9) != 0) : ($urandom_range(7) == 0));
    send_sample(s);
    repeat (holds) begin
      s = key_sample(key, $urandom_range(15) == 0);
      if ($urandom_range(3) == 0) begin
        noise = $urandom_range(63);
        s = s & noise;
      end
      send_sample(s);
    end
    repeat ($urandom_range(1, 2)) send_sample(key_sample(TRK_IDLE, $urandom_range(9) == 0));
  endtask

  task automatic random_sequence();
    logic [5:0]  raw;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 85) begin
      press_key(TrackedKeys[3'($urandom_range(4))], pick_hold());
    end else begin
      repeat ($urandom_range(1, 4)) begin
        raw = $urandom_range(63);
        send_sample(raw);
      end
    end
  endtask

  // Waits until every predicted code has arrived and the block has gone quiet.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (codes_pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic load_settings(input cfg_t c);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_LOCK_MODE;
    cfg_wdata <= CfgDataW'(c.lock_mode);
    @(posedge clk);
    cfg_addr  <= CFG_SHORT_TICKS;
    cfg_wdata <= CfgDataW'(c.short_ticks);
    @(posedge clk);
    cfg_addr  <= CFG_LONG_TICKS;
    cfg_wdata <= CfgDataW'(c.long_ticks);
    @(posedge clk);
    cfg_addr  <= CFG_TIMEOUT_TICKS;
    cfg_wdata <= CfgDataW'(c.timeout_ticks);
    @(posedge clk);
    cfg_we    <= 1'b0;
    active_cfg = c;
  endtask

  initial begin : stimulus
    int unsigned phase_start;
    active_cfg = make_cfg(1'b0, RST_SHORT_TICKS, RST_LONG_TICKS, RST_TIMEOUT_TICKS);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed presses under tight thresholds: one of each key code family.
    load_settings(make_cfg(1'b0, 8'd1, 8'd2, 10'd3));
    press_key(TRK_DOWN, 2);
    press_key(TRK_UP, 3);
    press_key(TRK_PLAY, 0);
    press_key(TRK_RECORD, 0);
    press_key(TRK_SET, 0);
    // A set key sample with no interrupt flag, ignored unless one is still pending.
    send_sample(key_sample(TRK_SET, 1'b0));
    // All keys at once: the down key wins.
    send_sample('0);
    send_sample(key_sample(TRK_DOWN, 1'b0));
    send_sample(key_sample(TRK_IDLE, 1'b0));

    for (int unsigned p = 0; p < NumPhases; p++) begin
      if (p == 3) begin
        send_idle_pct = 70;
        recv_idle_pct = 36;
      end else if (p == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      drain();
      load_settings(phase_cfg(p));
      if (p == 1) begin
        // Every down press reports at once here, so a held receiver backs up the block.
        stall_requests <= stall_requests + 1;
        repeat (12) press_key(TRK_DOWN, 1);
      end
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) random_sequence();
    end
    drain();

    $display("Run covered %0d key samples and %0d checked key codes over %0d register settings,",
             samples_taken, codes_checked, NumPhases + 1);
    $display("with sender and receiver stalls in turn and one long receiver hold-off.");
    if (mismatches == 0 && codes_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
